// ===== sv/bpc_pkg.sv =====
// ============================================================================
// Barometric compensation package
// Widths, scaling constants, register indexes and the structures that pass
// between the pipeline segments of the compensation block.
// ============================================================================
package bpc_pkg;

  localparam int RAW_W      = 24;
  localparam int COEFF_W    = 16;
  localparam int TEMP_W     = 19;
  localparam int PRESS_W    = 28;
  localparam int CFG_IDX_W  = 3;

  localparam int REF_SCALE  = 8;
  localparam int OFF_SCALE  = 16;
  localparam int SENS_SCALE = 15;
  localparam int SH_TEMP    = 23;
  localparam int SH_OFF     = 7;
  localparam int SH_SENS    = 8;
  localparam int SH_T2      = 31;
  localparam int SH_PROD    = 21;
  localparam int SH_PRESS   = 15;

  localparam int T_REF      = 2000;
  localparam int T_COLD     = -1500;

  localparam int DT_W       = RAW_W + 1;
  localparam int MUL_W      = DT_W + COEFF_W + 1;
  localparam int DD_W       = 2 * DT_W;
  localparam int T2_W       = DD_W - SH_T2 - 1;
  localparam int SQ_W       = 2 * TEMP_W;
  localparam int ACC_W      = 40;
  localparam int SPLIT_W    = 20;
  localparam int LO_P_W     = RAW_W + SPLIT_W;
  localparam int HI_P_W     = RAW_W + 1 + ACC_W - SPLIT_W;
  localparam int PROD_W     = 64;
  localparam int Q_W        = PROD_W - SH_PROD + 1;

  localparam int SEG_STAGES = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_SENS_TEMP   = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COEFF_W-1:0] sens;
    logic [COEFF_W-1:0] offset;
    logic [COEFF_W-1:0] sens_temp;
    logic [COEFF_W-1:0] offset_temp;
    logic [COEFF_W-1:0] ref_temp;
    logic [COEFF_W-1:0] temp_slope;
  } coeff_t;

  typedef struct packed {
    logic [SEG_STAGES-1:0] load;
    logic [SEG_STAGES-1:0] vld;
  } stage_ctl_t;

  typedef struct packed {
    logic        [RAW_W-1:0]  d1;
    logic signed [TEMP_W-1:0] temp1;
    logic signed [TEMP_W-1:0] dtemp;
    logic signed [TEMP_W-1:0] dcold;
    logic signed [ACC_W-1:0]  off1;
    logic signed [ACC_W-1:0]  sens1;
    logic        [T2_W-1:0]   t2;
  } fo_t;

  typedef struct packed {
    logic        [RAW_W-1:0]  d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [ACC_W-1:0]  off;
    logic signed [ACC_W-1:0]  sens;
  } so_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0]  temperature_centideg;
    logic signed [PRESS_W-1:0] pressure_centimbar;
  } res_t;

endpackage

// ===== sv/bpc_in_if.sv =====
// ============================================================================
// Raw sample channel
// Valid/ready channel carrying one raw pressure and temperature pair.
// ============================================================================
interface bpc_in_if;
  logic                       valid;
  logic                       ready;
  logic [bpc_pkg::RAW_W-1:0]  raw_pressure;
  logic [bpc_pkg::RAW_W-1:0]  raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ===== sv/bpc_out_if.sv =====
// ============================================================================
// Compensated result channel
// Valid/ready channel carrying compensated temperature and pressure.
// ============================================================================
interface bpc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bpc_pkg::TEMP_W-1:0]  temperature_centideg;
  logic signed [bpc_pkg::PRESS_W-1:0] pressure_centimbar;

  modport source (output valid, output temperature_centideg, output pressure_centimbar,
                  input ready);
  modport sink (input valid, input temperature_centideg, input pressure_centimbar,
                output ready);
endinterface

// ===== sv/bpc_cfg_if.sv =====
// ============================================================================
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ============================================================================
interface bpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bpc_pkg::CFG_IDX_W-1:0] index;
  logic [bpc_pkg::COEFF_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/bpc_cfg_regs.sv =====
// ============================================================================
// Calibration coefficient registers
// Holds the six calibration coefficients; writes to unused indexes are dropped.
// ============================================================================
module bpc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_valid,
  output logic                          wr_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [bpc_pkg::COEFF_W-1:0]   wr_data,
  output bpc_pkg::coeff_t               coeffs
);

  bpc_pkg::coeff_t coeff_r;
  bpc_pkg::coeff_t coeff_nxt;

  assign wr_ready = 1'b1;
  assign coeffs   = coeff_r;

  always_comb begin
    coeff_nxt = coeff_r;
    unique case (wr_index)
      bpc_pkg::REG_SENS:        coeff_nxt.sens        = wr_data;
      bpc_pkg::REG_OFFSET:      coeff_nxt.offset      = wr_data;
      bpc_pkg::REG_SENS_TEMP:   coeff_nxt.sens_temp   = wr_data;
      bpc_pkg::REG_OFFSET_TEMP: coeff_nxt.offset_temp = wr_data;
      bpc_pkg::REG_REF_TEMP:    coeff_nxt.ref_temp    = wr_data;
      bpc_pkg::REG_TEMP_SLOPE:  coeff_nxt.temp_slope  = wr_data;
      default:                  coeff_nxt             = coeff_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
    end else if (wr_valid) begin
      coeff_r <= coeff_nxt;
    end
  end

endmodule

// ===== sv/bpc_stage_ctl.sv =====
// ============================================================================
// Pipeline segment control
// Valid bits and per-stage load enables for one segment of register stages.
// ============================================================================
module bpc_stage_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic                dn_ready,
  output bpc_pkg::stage_ctl_t ctl
);

  localparam int NS = bpc_pkg::SEG_STAGES;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] vld_src;
  logic [NS:0]   adv;

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    adv[NS] = dn_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign vld_src = {vld_r[NS-2:0], up_valid};

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      vld_nxt[i] = adv[i] ? vld_src[i] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign up_ready = adv[0];
  assign ctl.load = adv[NS-1:0];
  assign ctl.vld  = vld_r;

endmodule

// ===== sv/bpc_first_order.sv =====
// ============================================================================
// First-order compensation segment
// Forms the temperature difference, the coefficient products and the
// first-order temperature, offset and sensitivity in three stages.
// ============================================================================
module bpc_first_order (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [bpc_pkg::RAW_W-1:0] raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0] raw_temperature,
  input  bpc_pkg::coeff_t           coeffs,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output bpc_pkg::fo_t              dn_data
);

  localparam int RAW_W   = bpc_pkg::RAW_W;
  localparam int DT_W    = bpc_pkg::DT_W;
  localparam int MUL_W   = bpc_pkg::MUL_W;
  localparam int DD_W    = bpc_pkg::DD_W;
  localparam int TEMP_W  = bpc_pkg::TEMP_W;
  localparam int ACC_W   = bpc_pkg::ACC_W;
  localparam int COEFF_W = bpc_pkg::COEFF_W;
  localparam int T2_W    = bpc_pkg::T2_W;

  bpc_pkg::stage_ctl_t ctl;

  logic        [RAW_W-1:0]  d1_s1_r;
  logic signed [DT_W-1:0]   dt_r;
  logic signed [DT_W-1:0]   dt_nxt;

  logic        [RAW_W-1:0]  d1_s2_r;
  logic signed [MUL_W-1:0]  ts_r;
  logic signed [MUL_W-1:0]  ts_nxt;
  logic signed [MUL_W-1:0]  po_r;
  logic signed [MUL_W-1:0]  po_nxt;
  logic signed [MUL_W-1:0]  ps_r;
  logic signed [MUL_W-1:0]  ps_nxt;
  logic signed [DD_W-1:0]   dd_r;
  logic signed [DD_W-1:0]   dd_nxt;

  logic signed [TEMP_W-1:0] dtemp;
  bpc_pkg::fo_t             fo_r;
  bpc_pkg::fo_t             fo_nxt;

  bpc_stage_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (up_valid),
    .up_ready (up_ready),
    .dn_ready (dn_ready),
    .ctl      (ctl)
  );

  assign dt_nxt = $signed({1'b0, raw_temperature})
                - $signed({1'b0, coeffs.ref_temp, {bpc_pkg::REF_SCALE{1'b0}}});

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      d1_s1_r <= raw_pressure;
      dt_r    <= dt_nxt;
    end
  end

  assign ts_nxt = dt_r * $signed({1'b0, coeffs.temp_slope});
  assign po_nxt = dt_r * $signed({1'b0, coeffs.offset_temp});
  assign ps_nxt = dt_r * $signed({1'b0, coeffs.sens_temp});
  assign dd_nxt = dt_r * dt_r;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      d1_s2_r <= d1_s1_r;
      ts_r    <= ts_nxt;
      po_r    <= po_nxt;
      ps_r    <= ps_nxt;
      dd_r    <= dd_nxt;
    end
  end

  assign dtemp = ts_r[MUL_W-1:bpc_pkg::SH_TEMP];

  always_comb begin
    fo_nxt.d1    = d1_s2_r;
    fo_nxt.dtemp = dtemp;
    fo_nxt.temp1 = dtemp + TEMP_W'(bpc_pkg::T_REF);
    fo_nxt.dcold = dtemp + TEMP_W'(bpc_pkg::T_REF - bpc_pkg::T_COLD);
    fo_nxt.off1  = ACC_W'($signed(po_r[MUL_W-1:bpc_pkg::SH_OFF]))
                 + $signed({{(ACC_W - COEFF_W - bpc_pkg::OFF_SCALE){1'b0}},
                            coeffs.offset, {bpc_pkg::OFF_SCALE{1'b0}}});
    fo_nxt.sens1 = ACC_W'($signed(ps_r[MUL_W-1:bpc_pkg::SH_SENS]))
                 + $signed({{(ACC_W - COEFF_W - bpc_pkg::SENS_SCALE){1'b0}},
                            coeffs.sens, {bpc_pkg::SENS_SCALE{1'b0}}});
    fo_nxt.t2    = dd_r[bpc_pkg::SH_T2+T2_W-1:bpc_pkg::SH_T2];
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      fo_r <= fo_nxt;
    end
  end

  assign dn_valid = ctl.vld[2];
  assign dn_data  = fo_r;

endmodule

// ===== sv/bpc_second_order.sv =====
// ============================================================================
// Second-order correction segment
// Squares the temperature deviations, forms the low and very low temperature
// corrections and applies them in three stages.
// ============================================================================
module bpc_second_order (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  bpc_pkg::fo_t up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output bpc_pkg::so_t dn_data
);

  localparam int TEMP_W = bpc_pkg::TEMP_W;
  localparam int SQ_W   = bpc_pkg::SQ_W;
  localparam int ACC_W  = bpc_pkg::ACC_W;

  bpc_pkg::stage_ctl_t ctl;

  bpc_pkg::fo_t            fo_s4_r;
  logic signed [SQ_W-1:0]  f_r;
  logic signed [SQ_W-1:0]  f_nxt;
  logic signed [SQ_W-1:0]  g_r;
  logic signed [SQ_W-1:0]  g_nxt;

  logic signed [ACC_W-1:0] f_ext;
  logic signed [ACC_W-1:0] g_ext;
  logic signed [ACC_W-1:0] five_f;
  logic signed [ACC_W-1:0] seven_g;
  logic signed [ACC_W-1:0] eleven_g;
  logic                    cold_s4;
  bpc_pkg::fo_t            fo_s5_r;
  logic signed [ACC_W-1:0] off2_r;
  logic signed [ACC_W-1:0] off2_nxt;
  logic signed [ACC_W-1:0] sens2_r;
  logic signed [ACC_W-1:0] sens2_nxt;

  logic                    low_s5;
  bpc_pkg::so_t            so_r;
  bpc_pkg::so_t            so_nxt;

  bpc_stage_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (up_valid),
    .up_ready (up_ready),
    .dn_ready (dn_ready),
    .ctl      (ctl)
  );

  assign f_nxt = $signed(up_data.dtemp) * $signed(up_data.dtemp);
  assign g_nxt = $signed(up_data.dcold) * $signed(up_data.dcold);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      fo_s4_r <= up_data;
      f_r     <= f_nxt;
      g_r     <= g_nxt;
    end
  end

  assign f_ext    = ACC_W'(f_r);
  assign g_ext    = ACC_W'(g_r);
  assign five_f   = (f_ext <<< 2) + f_ext;
  assign seven_g  = (g_ext <<< 3) - g_ext;
  assign eleven_g = (g_ext <<< 3) + (g_ext <<< 1) + g_ext;
  assign cold_s4  = fo_s4_r.dcold[TEMP_W-1];

  assign off2_nxt  = (five_f >>> 1) + (cold_s4 ? seven_g : '0);
  assign sens2_nxt = (five_f >>> 2) + (cold_s4 ? (eleven_g >>> 1) : '0);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      fo_s5_r <= fo_s4_r;
      off2_r  <= off2_nxt;
      sens2_r <= sens2_nxt;
    end
  end

  assign low_s5 = fo_s5_r.dtemp[TEMP_W-1];

  always_comb begin
    so_nxt.d1   = fo_s5_r.d1;
    so_nxt.temp = fo_s5_r.temp1 - (low_s5 ? $signed({1'b0, fo_s5_r.t2}) : '0);
    so_nxt.off  = fo_s5_r.off1 - (low_s5 ? off2_r : '0);
    so_nxt.sens = fo_s5_r.sens1 - (low_s5 ? sens2_r : '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      so_r <= so_nxt;
    end
  end

  assign dn_valid = ctl.vld[2];
  assign dn_data  = so_r;

endmodule

// ===== sv/bpc_press_mult.sv =====
// ============================================================================
// Pressure product segment
// Multiplies the raw pressure by the sensitivity as two partial products,
// joins them and removes the offset; the last stage is the result register.
// ============================================================================
module bpc_press_mult (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  bpc_pkg::so_t  up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output bpc_pkg::res_t dn_data
);

  localparam int TEMP_W  = bpc_pkg::TEMP_W;
  localparam int ACC_W   = bpc_pkg::ACC_W;
  localparam int SPLIT_W = bpc_pkg::SPLIT_W;
  localparam int LO_P_W  = bpc_pkg::LO_P_W;
  localparam int HI_P_W  = bpc_pkg::HI_P_W;
  localparam int PROD_W  = bpc_pkg::PROD_W;
  localparam int Q_W     = bpc_pkg::Q_W;
  localparam int PRESS_W = bpc_pkg::PRESS_W;

  bpc_pkg::stage_ctl_t ctl;

  logic signed [TEMP_W-1:0] temp_s7_r;
  logic signed [ACC_W-1:0]  off_s7_r;
  logic        [LO_P_W-1:0] p_lo_r;
  logic        [LO_P_W-1:0] p_lo_nxt;
  logic signed [HI_P_W-1:0] p_hi_r;
  logic signed [HI_P_W-1:0] p_hi_nxt;

  logic signed [TEMP_W-1:0] temp_s8_r;
  logic signed [ACC_W-1:0]  off_s8_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  logic signed [Q_W-1:0]    q;
  bpc_pkg::res_t            res_r;
  bpc_pkg::res_t            res_nxt;

  bpc_stage_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (up_valid),
    .up_ready (up_ready),
    .dn_ready (dn_ready),
    .ctl      (ctl)
  );

  assign p_lo_nxt = up_data.d1 * up_data.sens[SPLIT_W-1:0];
  assign p_hi_nxt = $signed({1'b0, up_data.d1}) * $signed(up_data.sens[ACC_W-1:SPLIT_W]);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      temp_s7_r <= up_data.temp;
      off_s7_r  <= up_data.off;
      p_lo_r    <= p_lo_nxt;
      p_hi_r    <= p_hi_nxt;
    end
  end

  assign prod_nxt = $signed({p_hi_r[PROD_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}})
                  + $signed({{(PROD_W - LO_P_W){1'b0}}, p_lo_r});

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      temp_s8_r <= temp_s7_r;
      off_s8_r  <= off_s7_r;
      prod_r    <= prod_nxt;
    end
  end

  assign q = Q_W'($signed(prod_r[PROD_W-1:bpc_pkg::SH_PROD])) - Q_W'(off_s8_r);

  always_comb begin
    res_nxt.temperature_centideg = temp_s8_r;
    res_nxt.pressure_centimbar   = q[bpc_pkg::SH_PRESS+PRESS_W-1:bpc_pkg::SH_PRESS];
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      res_r <= res_nxt;
    end
  end

  assign dn_valid = ctl.vld[2];
  assign dn_data  = res_r;

endmodule

// ===== sv/barometric_pressure_compensation.sv =====
// ============================================================================
// Barometric pressure compensation
// Second-order compensation of raw pressure and temperature conversions.
// ============================================================================
// The in_if channel takes one raw pressure and raw temperature pair per
// transfer; the out_if channel gives one compensated temperature (0.01 C) and
// pressure (0.01 mbar) per input, in input order. The six calibration
// coefficients are written over cfg_if, whose ready is always high; a write
// to an index above five is dropped. Coefficients are to be written only
// while no item is in flight.
// The datapath is a nine-stage pipeline: three stages for the first-order
// terms, three for the second-order correction and three for the pressure
// product, the last of which is the output register. While the receiver
// takes results, one item can be taken every cycle. Latency is set by the
// dependent multiplies.
// Each stage has its own valid bit, so when the receiver stalls the pipeline
// keeps taking items until every stage is full, then deasserts in_if.ready.
// Reset clears all valid bits and all coefficients to zero.
// ============================================================================
module barometric_pressure_compensation (
  input  logic       clk,
  input  logic       rst_n,
  bpc_in_if.sink     in_if,
  bpc_out_if.source  out_if,
  bpc_cfg_if.sink    cfg_if
);

  bpc_pkg::coeff_t coeffs;
  bpc_pkg::fo_t    fo_data;
  bpc_pkg::so_t    so_data;
  bpc_pkg::res_t   res_data;
  logic            fo_valid;
  logic            fo_ready;
  logic            so_valid;
  logic            so_ready;
  logic            in_ready;
  logic            res_valid;

  bpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_if.valid),
    .wr_ready (cfg_if.ready),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .coeffs   (coeffs)
  );

  bpc_first_order u_first (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (in_if.valid),
    .up_ready        (in_ready),
    .raw_pressure    (in_if.raw_pressure),
    .raw_temperature (in_if.raw_temperature),
    .coeffs          (coeffs),
    .dn_valid        (fo_valid),
    .dn_ready        (fo_ready),
    .dn_data         (fo_data)
  );

  bpc_second_order u_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fo_valid),
    .up_ready (fo_ready),
    .up_data  (fo_data),
    .dn_valid (so_valid),
    .dn_ready (so_ready),
    .dn_data  (so_data)
  );

  bpc_press_mult u_press (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (so_valid),
    .up_ready (so_ready),
    .up_data  (so_data),
    .dn_valid (res_valid),
    .dn_ready (out_if.ready),
    .dn_data  (res_data)
  );

  assign in_if.ready                 = in_ready;
  assign out_if.valid                = res_valid;
  assign out_if.temperature_centideg = res_data.temperature_centideg;
  assign out_if.pressure_centimbar   = res_data.pressure_centimbar;

`ifndef SYNTHESIS
  // The input side only backs up when every stage holds an item and the
  // receiver is stalled.
  a_backpressure_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_ready |-> (res_valid && !out_if.ready && so_valid && fo_valid)
  ) else $error("input stalled while the pipeline has room");

  a_reset_empties: assert property (
    @(posedge clk)
    !rst_n |=> (!res_valid && !so_valid && !fo_valid)
  ) else $error("pipeline holds an item after reset");
`endif

endmodule
